// ===== src/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    // Operation codes carried by a command word
    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_ENQ = 2'd1,
        OP_DEQ = 2'd2
    } opcode_t;

    // Status codes carried by a response word
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Broadcast control from the controller to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/spq_cmd_if.sv =====
`default_nettype none

interface spq_cmd_if #(
    parameter int ELEM_BITS = 32,
    parameter int PRIO_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [ELEM_BITS-1:0] elem_in;
    logic [PRIO_BITS-1:0] prio_in;

    modport source (output valid, output opcode, output elem_in, output prio_in, input ready);
    modport sink   (input valid, input opcode, input elem_in, input prio_in, output ready);
endinterface

`default_nettype wire

// ===== src/spq_rsp_if.sv =====
`default_nettype none

interface spq_rsp_if #(
    parameter int ELEM_BITS = 32,
    parameter int PRIO_BITS = 16,
    parameter int CNT_BITS  = 5
);
    logic                 valid;
    logic                 ready;
    logic [ELEM_BITS-1:0] head_elem;
    logic [PRIO_BITS-1:0] head_prio;
    logic [CNT_BITS-1:0]  entry_count;
    logic                 is_empty;
    logic [1:0]           status;

    modport source (
        output valid, output head_elem, output head_prio, output entry_count,
        output is_empty, output status, input ready
    );
    modport sink (
        input valid, input head_elem, input head_prio, input entry_count,
        input is_empty, input status, output ready
    );
endinterface

`default_nettype wire

// ===== src/spq_cell.sv =====
`default_nettype none

// One slot of the sorted chain. Slots below the fill count are occupied and
// sorted by ascending priority from slot 0 upward.
module spq_cell #(
    parameter int IDX       = 0,
    parameter int PRIO_BITS = 16,
    parameter int ELEM_BITS = 32,
    parameter int CNT_BITS  = 5
) (
    input  wire                         clk,
    input  spq_pkg::cell_ctl_t          ctl,
    input  wire logic [CNT_BITS-1:0]    count,
    input  wire logic [PRIO_BITS-1:0]   new_prio,
    input  wire logic [ELEM_BITS-1:0]   new_elem,
    input  wire logic                   left_after,
    input  wire logic [PRIO_BITS-1:0]   left_prio,
    input  wire logic [ELEM_BITS-1:0]   left_elem,
    input  wire logic [PRIO_BITS-1:0]   right_prio,
    input  wire logic [ELEM_BITS-1:0]   right_elem,
    output logic                        after,
    output logic [PRIO_BITS-1:0]        prio,
    output logic [ELEM_BITS-1:0]        elem
);

    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [ELEM_BITS-1:0] elem_reg, elem_next;
    logic                 occupied;

    // The new word goes behind this slot when it holds an equal or smaller priority
    assign occupied = CNT_BITS'(IDX) < count;
    assign after    = occupied && (prio_reg <= new_prio);
    assign prio     = prio_reg;
    assign elem     = elem_reg;

    // Hold, insert, shift down on enqueue or shift up on dequeue
    always_comb
    begin
        prio_next = prio_reg;
        elem_next = elem_reg;
        if (ctl.enq)
        begin
            if (!after)
            begin
                if (left_after)
                begin
                    prio_next = new_prio;
                    elem_next = new_elem;
                end
                else
                begin
                    prio_next = left_prio;
                    elem_next = left_elem;
                end
            end
        end
        else if (ctl.deq)
        begin
            prio_next = right_prio;
            elem_next = right_elem;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        elem_reg <= elem_next;
    end

endmodule

`default_nettype wire

// ===== src/spq_ctrl.sv =====
`default_nettype none

// Fill count, response valid and status; issues the broadcast to the cells.
module spq_ctrl #(
    parameter int DEPTH    = 16,
    parameter int CNT_BITS = 5
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire logic                 cmd_valid,
    input  wire logic [1:0]           opcode,
    input  wire logic                 rsp_ready,
    output logic                      cmd_ready,
    output logic                      rsp_valid,
    output spq_pkg::cell_ctl_t        ctl,
    output logic [CNT_BITS-1:0]       count,
    output spq_pkg::status_t          status
);

    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    spq_pkg::status_t    status_reg, status_next;
    logic                accept;
    logic                full;

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign full      = count_reg == CNT_BITS'(DEPTH);
    assign count     = count_reg;
    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;

    // Decode the accepted word: drop enqueue when full, flag dequeue when empty
    always_comb
    begin
        ctl         = '0;
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            status_next = spq_pkg::ST_OK;
            if (opcode == spq_pkg::OP_ENQ)
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    ctl.enq    = 1'b1;
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            else if (opcode == spq_pkg::OP_DEQ)
            begin
                if (count_reg == '0)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctl.deq    = 1'b1;
                    count_next = count_reg - CNT_BITS'(1);
                end
            end
        end
    end

    // Response is pending from acceptance until the sink takes it
    always_comb
    begin
        priority if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

// ===== src/stable_min_priority_queue_top.sv =====
// Stable minimum priority queue, kept as a sorted chain of DEPTH slots.
// Command channel (cmd): opcode, elem_in, prio_in. Opcode NOP reports status,
// ENQ inserts the word behind every stored entry of equal or smaller priority
// (equal priorities leave in arrival order), DEQ removes the head.
// Response channel (rsp): one word per command with head_elem, head_prio,
// entry_count and is_empty as they stand after the operation, and status
// (ok, enqueue dropped because full, dequeue on empty). Head fields read zero
// when the queue is empty.
// The response is valid in the cycle after the command is accepted.
// Throughput: one command per cycle while no response is stalled; every slot
// compares its priority with the new one in parallel and the whole chain shifts together.
// The response is read straight from the slot registers and the fill count,
// so while a response waits the queue holds and cmd.ready stays low; a new
// command is taken in the same cycle the pending response is taken.
// Reset empties the queue at once (fill count zero); slot contents are not
// cleared, only occupied slots are ever read.
`default_nettype none

module stable_min_priority_queue_top #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 16,
    parameter int ELEM_BITS = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    spq_cmd_if.sink    cmd,
    spq_rsp_if.source  rsp
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    spq_pkg::cell_ctl_t   ctl;
    spq_pkg::status_t     status;
    logic [CNT_BITS-1:0]  count;
    logic                 rsp_valid;
    logic                 cmd_ready;
    logic                 after_q [DEPTH];
    logic [PRIO_BITS-1:0] prio_q  [DEPTH];
    logic [ELEM_BITS-1:0] elem_q  [DEPTH];

    spq_ctrl #(
        .DEPTH    (DEPTH),
        .CNT_BITS (CNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .opcode    (cmd.opcode),
        .rsp_ready (rsp.ready),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .ctl       (ctl),
        .count     (count),
        .status    (status)
    );

    // Build the chain; slot 0 sees the new word as its left neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 l_after;
        logic [PRIO_BITS-1:0] l_prio;
        logic [ELEM_BITS-1:0] l_elem;
        logic [PRIO_BITS-1:0] r_prio;
        logic [ELEM_BITS-1:0] r_elem;

        if (i == 0)
        begin : g_first
            assign l_after = 1'b1;
            assign l_prio  = cmd.prio_in;
            assign l_elem  = cmd.elem_in;
        end
        else
        begin : g_inner_l
            assign l_after = after_q[i-1];
            assign l_prio  = prio_q[i-1];
            assign l_elem  = elem_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_prio = cmd.prio_in;
            assign r_elem = cmd.elem_in;
        end
        else
        begin : g_inner_r
            assign r_prio = prio_q[i+1];
            assign r_elem = elem_q[i+1];
        end

        spq_cell #(
            .IDX       (i),
            .PRIO_BITS (PRIO_BITS),
            .ELEM_BITS (ELEM_BITS),
            .CNT_BITS  (CNT_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count),
            .new_prio   (cmd.prio_in),
            .new_elem   (cmd.elem_in),
            .left_after (l_after),
            .left_prio  (l_prio),
            .left_elem  (l_elem),
            .right_prio (r_prio),
            .right_elem (r_elem),
            .after      (after_q[i]),
            .prio       (prio_q[i]),
            .elem       (elem_q[i])
        );
    end

    // Drive the response word from the head slot and the fill count
    assign cmd.ready       = cmd_ready;
    assign rsp.valid       = rsp_valid;
    assign rsp.entry_count = count;
    assign rsp.is_empty    = count == '0;
    assign rsp.head_elem   = (count == '0) ? '0 : elem_q[0];
    assign rsp.head_prio   = (count == '0) ? '0 : prio_q[0];
    assign rsp.status      = status;

endmodule

`default_nettype wire

// ===== src/spq_checker.sv =====
`default_nettype none

module spq_checker #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 16,
    parameter int ELEM_BITS = 32,
    parameter int CNT_BITS  = 5
) (
    input wire                       clk,
    input wire                       rst_n,
    input wire logic                 cmd_ready,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic [ELEM_BITS-1:0] head_elem,
    input wire logic [PRIO_BITS-1:0] head_prio,
    input wire logic [CNT_BITS-1:0]  entry_count,
    input wire logic                 is_empty,
    input wire logic [1:0]           status
);

    // Empty flag and head fields agree with the count
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (entry_count == '0) |->
            is_empty && (head_elem == '0) && (head_prio == '0))
        else $error("empty response shows a head or no empty flag");

    // A dropped enqueue only happens on a full queue
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == spq_pkg::ST_FULL) |-> entry_count == CNT_BITS'(DEPTH))
        else $error("full status with a queue that is not full");

    // A failed dequeue leaves the queue empty
    a_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == spq_pkg::ST_EMPTY) |-> is_empty)
        else $error("empty status with a queue that holds entries");

    // A stalled response blocks new commands
    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !cmd_ready)
        else $error("command taken while a response is stalled");

    // A stalled response stays valid and holds its head fields and entry count
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(head_elem) && $stable(head_prio) && $stable(entry_count))
        else $error("stalled response changed");

endmodule

bind stable_min_priority_queue_top spq_checker #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS),
    .ELEM_BITS (ELEM_BITS),
    .CNT_BITS  (CNT_BITS)
) u_spq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .head_elem   (rsp.head_elem),
    .head_prio   (rsp.head_prio),
    .entry_count (rsp.entry_count),
    .is_empty    (rsp.is_empty),
    .status      (rsp.status)
);

`default_nettype wire

// ===== dv/stable_min_priority_queue_top_tb.sv =====
`timescale 1ns / 100ps

module stable_min_priority_queue_top_tb;

    localparam int DEPTH        = 16;
    localparam int PRIO_BITS    = 16;
    localparam int ELEM_BITS    = 32;
    localparam int CNT_BITS     = 5;
    localparam int IDLE_PCT     = 18;
    localparam int QUIET_FROM   = 1500;
    localparam int QUIET_TO     = 2300;
    localparam int HOLD_START   = 600;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 5;
    localparam int MAX_REPORTS  = 40;

    // Opcode outside the defined set; the block treats it as a status query
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ELEM_BITS-1:0] head_elem;
        logic [PRIO_BITS-1:0] head_prio;
        logic [CNT_BITS-1:0]  entry_count;
        logic                 is_empty;
        spq_pkg::status_t     status;
    } head_report_t;

    // Shadow copy of the sorted queue plus the head reports still owed
    class pq_scoreboard;
        logic [PRIO_BITS-1:0] slot_prio[DEPTH];
        logic [ELEM_BITS-1:0] slot_elem[DEPTH];
        int                   fill;
        head_report_t         pending_reports[$];
        int                   mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // Apply one accepted command word and queue the head report it yields
        function void note_command(logic [1:0] op, logic [ELEM_BITS-1:0] elem,
                                   logic [PRIO_BITS-1:0] prio);
            head_report_t rep;
            int           pos;
            int           k;
            rep.status = spq_pkg::ST_OK;
            if (op == spq_pkg::OP_ENQ) begin
                if (fill >= DEPTH) begin
                    rep.status = spq_pkg::ST_FULL;
                end
                else begin
                    // place behind every entry of equal or smaller priority
                    pos = 0;
                    while (pos < fill && slot_prio[pos] <= prio)
                        pos++;
                    for (k = fill; k > pos; k--) begin
                        slot_prio[k] = slot_prio[k-1];
                        slot_elem[k] = slot_elem[k-1];
                    end
                    slot_prio[pos] = prio;
                    slot_elem[pos] = elem;
                    fill++;
                end
            end
            else if (op == spq_pkg::OP_DEQ) begin
                if (fill == 0) begin
                    rep.status = spq_pkg::ST_EMPTY;
                end
                else begin
                    for (k = 0; k + 1 < fill; k++) begin
                        slot_prio[k] = slot_prio[k+1];
                        slot_elem[k] = slot_elem[k+1];
                    end
                    fill--;
                end
            end
            rep.head_elem   = (fill > 0) ? slot_elem[0] : '0;
            rep.head_prio   = (fill > 0) ? slot_prio[0] : '0;
            rep.entry_count = CNT_BITS'(fill);
            rep.is_empty    = (fill == 0);
            pending_reports.push_back(rep);
        endfunction

        function void compare_field(string name, logic [ELEM_BITS-1:0] exp_val,
                                    logic [ELEM_BITS-1:0] act_val);
            if (exp_val !== act_val) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %h actual %h",
                             $time, name, exp_val, act_val);
            end
        endfunction

        // Compare one accepted response word with the oldest owed report
        function void check_report(head_report_t act);
            head_report_t exp_rep;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: response word with none expected, expected none actual %h",
                             $time, act);
                return;
            end
            exp_rep = pending_reports.pop_front();
            compare_field("head_elem", exp_rep.head_elem, act.head_elem);
            compare_field("head_prio", ELEM_BITS'(exp_rep.head_prio),
                          ELEM_BITS'(act.head_prio));
            compare_field("entry_count", ELEM_BITS'(exp_rep.entry_count),
                          ELEM_BITS'(act.entry_count));
            compare_field("is_empty", ELEM_BITS'(exp_rep.is_empty),
                          ELEM_BITS'(act.is_empty));
            compare_field("status", ELEM_BITS'(exp_rep.status), ELEM_BITS'(act.status));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count = 0;

    spq_cmd_if #(.ELEM_BITS(ELEM_BITS), .PRIO_BITS(PRIO_BITS)) cmd_ch ();
    spq_rsp_if #(.ELEM_BITS(ELEM_BITS), .PRIO_BITS(PRIO_BITS), .CNT_BITS(CNT_BITS)) rsp_ch ();

    stable_min_priority_queue_top #(
        .DEPTH    (DEPTH),
        .PRIO_BITS(PRIO_BITS),
        .ELEM_BITS(ELEM_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .rsp  (rsp_ch)
    );

    pq_scoreboard board = new();

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit quiet_window();
        return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
    endfunction

    // Priorities crowd a few small values so ties are common
    function automatic logic [PRIO_BITS-1:0] pick_priority();
        case ($urandom_range(3))
            0, 1: return PRIO_BITS'($urandom_range(7));
            2:    return PRIO_BITS'($urandom);
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    // Offer one command word, idle first at random, hold until taken
    task automatic send_command(logic [1:0] op, logic [ELEM_BITS-1:0] elem,
                                logic [PRIO_BITS-1:0] prio);
        while (!quiet_window() && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.opcode  <= op;
        cmd_ch.elem_in <= elem;
        cmd_ch.prio_in <= prio;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        board.note_command(op, elem, prio);
    endtask

    task automatic run_directed();
        int i;
        // status, underflow and the unused opcode on an empty queue
        send_command(spq_pkg::OP_NOP, '0, '0);
        send_command(spq_pkg::OP_DEQ, '1, '1);
        send_command(OP_UNUSED, '1, '1);
        // extremes of element and priority
        send_command(spq_pkg::OP_ENQ, '1, '1);
        send_command(spq_pkg::OP_ENQ, '0, '0);
        // equal priorities must leave in arrival order
        send_command(spq_pkg::OP_ENQ, 32'hA5A5_0001, 16'h8000);
        send_command(spq_pkg::OP_ENQ, 32'h5A5A_0002, 16'h8000);
        // fill to the top
        for (i = 0; i < DEPTH - 4; i++)
            send_command(spq_pkg::OP_ENQ, $urandom,
                         (i % 3 == 0) ? 16'h8000 : pick_priority());
        // overflow and the unused opcode on a full queue, then a dequeue and a status query
        send_command(spq_pkg::OP_ENQ, $urandom, '0);
        send_command(OP_UNUSED, $urandom, PRIO_BITS'($urandom));
        send_command(spq_pkg::OP_DEQ, $urandom, PRIO_BITS'($urandom));
        send_command(spq_pkg::OP_NOP, $urandom, PRIO_BITS'($urandom));
    endtask

    task automatic run_random();
        int blk;
        int i;
        int enq_weight;
        int r;
        logic [1:0] op;
        for (blk = 0; blk < 27; blk++)
        begin
            // pick a filling, balanced or draining phase at random
            case ($urandom_range(2))
                0:       enq_weight = 80;
                1:       enq_weight = 50;
                default: enq_weight = 25;
            endcase
            for (i = 0; i < 50; i++)
            begin
                r = $urandom_range(99);
                if (r < 4)
                    op = OP_UNUSED;
                else if (r < 10)
                    op = spq_pkg::OP_NOP;
                else if (r < 10 + enq_weight * 90 / 100)
                    op = spq_pkg::OP_ENQ;
                else
                    op = spq_pkg::OP_DEQ;
                send_command(op, $urandom, pick_priority());
            end
        end
    endtask

    // Response side: check taken words, stall at random, one long hold-off
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_report({rsp_ch.head_elem, rsp_ch.head_prio, rsp_ch.entry_count,
                                    rsp_ch.is_empty, spq_pkg::status_t'(rsp_ch.status)});
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && cycle_count >= HOLD_START)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= quiet_window() || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    // Command side and end of run
    initial
    begin
        rst_n           <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.opcode   <= spq_pkg::OP_NOP;
        cmd_ch.elem_in  <= '0;
        cmd_ch.prio_in  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        cmd_ch.valid <= 1'b0;
        while (board.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
